// ===== rtl/core/bsl_pkg.sv =====
// package for the band smoother and led trail block
// shared widths, register codes and reset values; no dependencies
package bsl_pkg;
	localparam int BandW = 24;
	localparam int IdxW = 4;
	localparam int WeightW = 16;
	localparam int LevelW = 17;
	localparam int BandCount = 12;
	localparam int PixelsDefault = 32;
	localparam logic [LevelW-1:0] OneQ16 = 17'h10000;

	localparam logic [2:0] RegFastRise = 3'd0;
	localparam logic [2:0] RegFastDecay = 3'd1;
	localparam logic [2:0] RegSlowRise = 3'd2;
	localparam logic [2:0] RegSlowDecay = 3'd3;
	localparam logic [2:0] RegTrailDecay = 3'd4;

	localparam logic [WeightW-1:0] FastRiseReset = 16'd39322;
	localparam logic [WeightW-1:0] FastDecayReset = 16'd26214;
	localparam logic [WeightW-1:0] SlowRiseReset = 16'd64881;
	localparam logic [WeightW-1:0] SlowDecayReset = 16'd655;
	localparam logic [WeightW-1:0] TrailDecayReset = 16'd64225;

	typedef struct packed {
		logic [WeightW-1:0] fast_rise;
		logic [WeightW-1:0] fast_decay;
		logic [WeightW-1:0] slow_rise;
		logic [WeightW-1:0] slow_decay;
		logic [WeightW-1:0] trail_decay;
	} cfg_t;
endpackage

// ===== rtl/core/bsl_divider.sv =====
// restoring divider for the clamped ratio, one quotient bit per cycle
// depends on bsl_pkg
module bsl_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bsl_pkg::BandW-1:0] num,
	input  logic [bsl_pkg::BandW-1:0] den,
	output logic                      done,
	output logic [bsl_pkg::LevelW-1:0] ratio
);
	import bsl_pkg::*;
	// quotient of (num<<16)/den; only 17 quotient bits matter after clamping
	localparam int NumW = BandW + 16;
	logic [NumW-1:0] rem_q;
	logic [NumW-1:0] dvd_q;
	logic [LevelW:0] quo_q;
	logic            big_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic [NumW:0]   trial;
	logic [NumW-1:0] shifted;

	always_comb begin
		shifted = {rem_q[NumW-2:0], dvd_q[NumW-1]};
		trial = {1'b0, shifted} - {{(NumW-BandW+1){1'b0}}, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NumW);
				rem_q <= '0;
				dvd_q <= {num, 16'h0};
				quo_q <= '0;
				big_q <= 1'b0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[NumW-2:0], 1'b0};
				if (!trial[NumW]) begin
					rem_q <= trial[NumW-1:0];
					if (cnt_q > 6'(LevelW + 1)) big_q <= 1'b1;
					quo_q <= {quo_q[LevelW-1:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[LevelW-1:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign ratio = (big_q || quo_q > {1'b0, OneQ16}) ? OneQ16 : quo_q[LevelW-1:0];
endmodule

// ===== rtl/core/band_smoother_led_trail_unit.sv =====
// top level of the band smoother and led trail block
// holds registers, sequencer, shared multiplier and trail; uses bsl_pkg, bsl_divider
//
// channel  dir  fields (low bit up)
// s_axis   in   tdata: band_value[23:0] band_index[27:24]
// m_axis   out  tdata: pixel_offset[5:0] red[13:6] green[21:14] blue[29:22]; tlast
// apb      cfg  five 16-bit registers at byte 0,4,8,12,16
//
// a band holds the input closed for four multiply steps, a divide start, the wait on
// the 40-step divider and a max update; no divider wait when the reference is zero
// band 11 adds a trail walk, T1-T3 per shifted pixel and pixel 0, then one pixel per cycle
// reset clears all smoother, maxima and trail state at once
// output stalls hold the emit; no item is taken until the frame is emitted
module band_smoother_led_trail_unit #(
	parameter int PIXELS_PER_SIDE = bsl_pkg::PixelsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // band_value, band_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // pixel_offset, red, green, blue
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsl_pkg::*;
	localparam int PixW = (PIXELS_PER_SIDE > 1) ? $clog2(PIXELS_PER_SIDE) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_F1, ST_F2, ST_S1, ST_S2, ST_DIV, ST_DWAIT, ST_MAX,
		ST_T1, ST_T2, ST_T3, ST_EMIT
	} state_t;

	state_t state_q;
	cfg_t cfg_q;
	logic [BandW-1:0] smooth_q [BandCount];
	logic [BandW-1:0] ref_q [BandCount];
	logic [LevelW-1:0] max_q [3];
	logic [LevelW-1:0] tr_q [PIXELS_PER_SIDE];
	logic [LevelW-1:0] tg_q [PIXELS_PER_SIDE];
	logic [LevelW-1:0] tb_q [PIXELS_PER_SIDE];
	logic [BandW-1:0] val_q, old_q, new_s_q, new_r_q;
	logic [IdxW-1:0] idx_q;
	logic [WeightW:0] w_q;
	logic [41:0] acc_q;
	logic [PixW-1:0] pix_q;
	logic [LevelW-1:0] prev_q;

	// shared multiplier: 24 x 17
	logic [BandW-1:0] ma;
	logic [WeightW:0] mb;
	logic [40:0] prod;
	assign prod = ma * mb;

	logic div_start, div_done;
	logic [LevelW-1:0] ratio;
	bsl_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(new_s_q), .den(new_r_q), .done(div_done), .ratio(ratio)
	);

	logic [1:0] colour;
	assign colour = (idx_q < 4'd4) ? 2'd0 : (idx_q < 4'd8) ? 2'd1 : 2'd2;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign pready = 1'b1;
	assign div_start = (state_q == ST_DIV) && (new_r_q != '0);

	function automatic logic [7:0] to_byte(input logic [LevelW-1:0] v);
		logic [LevelW+7:0] b;
		b = {8'h0, v} * 25'd255;
		return (b[LevelW+7:16] > 9'd255) ? 8'hff : b[23:16];
	endfunction

	always_comb begin
		ma = old_q;
		mb = w_q;
		case (state_q)
			ST_F1, ST_S1: begin ma = old_q; mb = 17'h10000 - w_q; end
			ST_F2, ST_S2: begin ma = val_q; mb = w_q; end
			ST_T1, ST_T2, ST_T3: begin ma = {7'h0, prev_q}; mb = {1'b0, cfg_q.trail_decay}; end
			default: begin ma = old_q; mb = w_q; end
		endcase
	end

	always_comb begin
		prdata = '0;
		case (paddr[4:2])
			RegFastRise: prdata = {16'h0, cfg_q.fast_rise};
			RegFastDecay: prdata = {16'h0, cfg_q.fast_decay};
			RegSlowRise: prdata = {16'h0, cfg_q.slow_rise};
			RegSlowDecay: prdata = {16'h0, cfg_q.slow_decay};
			RegTrailDecay: prdata = {16'h0, cfg_q.trail_decay};
			default: prdata = '0;
		endcase
	end

	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tlast = (32'(pix_q) == PIXELS_PER_SIDE - 1);
	assign m_axis_tdata = {2'b0, to_byte(tb_q[pix_q]), to_byte(tg_q[pix_q]),
		to_byte(tr_q[pix_q]), 6'(pix_q)};

	logic [LevelW-1:0] dec;
	assign dec = 17'((prod + 41'd32768) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q <= '{FastRiseReset, FastDecayReset, SlowRiseReset, SlowDecayReset,
				TrailDecayReset};
			for (int i = 0; i < BandCount; i++) begin
				smooth_q[i] <= '0;
				ref_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) max_q[i] <= '0;
			for (int i = 0; i < PIXELS_PER_SIDE; i++) begin
				tr_q[i] <= '0;
				tg_q[i] <= '0;
				tb_q[i] <= '0;
			end
			pix_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[4:2])
					RegFastRise: cfg_q.fast_rise <= pwdata[15:0];
					RegFastDecay: cfg_q.fast_decay <= pwdata[15:0];
					RegSlowRise: cfg_q.slow_rise <= pwdata[15:0];
					RegSlowDecay: cfg_q.slow_decay <= pwdata[15:0];
					RegTrailDecay: cfg_q.trail_decay <= pwdata[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tdata[27:24] < 4'(BandCount)) begin
						val_q <= s_axis_tdata[23:0];
						idx_q <= s_axis_tdata[27:24];
						old_q <= smooth_q[s_axis_tdata[27:24]];
						w_q <= (s_axis_tdata[23:0] > smooth_q[s_axis_tdata[27:24]])
							? {1'b0, cfg_q.fast_rise} : {1'b0, cfg_q.fast_decay};
						state_q <= ST_F1;
					end
				end
				ST_F1: begin acc_q <= {1'b0, prod} + 42'd32768; state_q <= ST_F2; end
				ST_F2: begin
					new_s_q <= 24'((acc_q + {1'b0, prod}) >> 16);
					smooth_q[idx_q] <= 24'((acc_q + {1'b0, prod}) >> 16);
					val_q <= 24'((acc_q + {1'b0, prod}) >> 16);
					old_q <= ref_q[idx_q];
					w_q <= (24'((acc_q + {1'b0, prod}) >> 16) > ref_q[idx_q])
						? {1'b0, cfg_q.slow_rise} : {1'b0, cfg_q.slow_decay};
					state_q <= ST_S1;
				end
				ST_S1: begin acc_q <= {1'b0, prod} + 42'd32768; state_q <= ST_S2; end
				ST_S2: begin
					new_r_q <= 24'((acc_q + {1'b0, prod}) >> 16);
					ref_q[idx_q] <= 24'((acc_q + {1'b0, prod}) >> 16);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (new_r_q == '0) begin
						if (new_s_q != '0) max_q[colour] <= OneQ16;
						state_q <= ST_MAX;
					end else state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (ratio > max_q[colour]) max_q[colour] <= ratio;
						state_q <= ST_MAX;
					end
				end
				ST_MAX: begin
					if (idx_q == 4'(BandCount - 1)) begin
						pix_q <= PixW'(PIXELS_PER_SIDE - 1);
						state_q <= ST_T1;
						if (PIXELS_PER_SIDE > 1) prev_q <= tr_q[PixW'(PIXELS_PER_SIDE - 2)];
					end else state_q <= ST_IDLE;
				end
				ST_T1, ST_T2, ST_T3: begin
					if (pix_q == '0) begin
						tr_q[0] <= max_q[0];
						tg_q[0] <= max_q[1];
						tb_q[0] <= max_q[2];
						for (int i = 0; i < 3; i++) max_q[i] <= '0;
						state_q <= ST_EMIT;
					end else begin
						case (state_q)
							ST_T1: begin
								tr_q[pix_q] <= dec;
								prev_q <= tg_q[pix_q - PixW'(1)];
								state_q <= ST_T2;
							end
							ST_T2: begin
								tg_q[pix_q] <= dec;
								prev_q <= tb_q[pix_q - PixW'(1)];
								state_q <= ST_T3;
							end
							default: begin
								tb_q[pix_q] <= dec;
								if (pix_q > PixW'(1)) prev_q <= tr_q[pix_q - PixW'(2)];
								pix_q <= pix_q - PixW'(1);
								state_q <= ST_T1;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						if (m_axis_tlast) begin
							pix_q <= '0;
							state_q <= ST_IDLE;
						end else pix_q <= pix_q + PixW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
